[rtl/core/dst_pkg.sv]
// Package for the digital search tree engine: status and mode codes, widths, and the command and status structs.
// Used by every file of the block but dst_if; depends on nothing.
package dst_pkg;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_SPARE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_FOUND    = 3'd4,
        ST_FULL     = 3'd5
    } status_t;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // Latch the request and start a walk at the root.
        logic rd_cur;      // Read the node held in the current pointer.
        logic step_find;   // Compare the node just read and descend.
        logic step_leaf;   // Descend towards a leaf on the node just read.
        logic do_insert;   // Take a free node and hang it.
        logic rd_leaf_key; // Read the key of the leaf found.
        logic do_remove;   // Move the leaf key, cut the leaf, free it.
    } dst_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cur_nil;     // Current pointer is the null link.
        logic key_hit;     // Node just read holds the key.
        logic is_leaf;     // Node just read has no children.
        logic pool_empty;  // No free node remains.
        logic filling;     // The post-reset fill pass is still running.
    } dst_stat_t;

endpackage

[rtl/core/dst_if.sv]
// Valid and ready channel carrying one request or one result.
// Payload widths are set by the parameters W0 and W1.
interface dst_if #(
    parameter int W0 = 2,
    parameter int W1 = 32
);
    logic          valid;
    logic          ready;
    logic [W0-1:0] f0;
    logic [W1-1:0] f1;

    modport source (output valid, f0, f1, input ready);
    modport sink   (input valid, f0, f1, output ready);
endinterface

[rtl/core/digital_search_tree_engine.sv]
// Digital search tree engine: a set of keys held in a node pool of POOL_SIZE
// nodes. Each request (insert, remove, search) gives one result with a status
// and the key count after it. One request is worked at a time, from one node
// memory read port; each level of the key search walk passes through a check,
// a read and a compare state. The two walks of a remove cover at most KEY_WIDTH+1
// levels together. A new request is taken only once the engine is idle again
// and no earlier result is left untaken. After reset a fill pass loads the
// free stack and clears the links; requests are held off until it ends.
module digital_search_tree_engine #(
    parameter int POOL_SIZE = 1024,
    parameter int KEY_WIDTH = 32
) (
    input logic clk,
    input logic rst_n,
    dst_if.sink   req,
    dst_if.source rsp
);
    import dst_pkg::*;

    localparam int LW = $clog2(POOL_SIZE + 1);

    dst_cmd_t  cmd;
    dst_stat_t stat;
    logic [LW-1:0] count;
    logic [LW-1:0] out_count;
    logic [STATUS_W-1:0] out_status;

    dst_ctrl #(.POOL_SIZE(POOL_SIZE)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready), .in_mode(req.f0[MODE_W-1:0]),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .out_status(out_status), .out_count(out_count),
        .count(count), .stat(stat), .cmd(cmd)
    );

    dst_datapath #(.POOL_SIZE(POOL_SIZE), .KEY_WIDTH(KEY_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_key(req.f1[KEY_WIDTH-1:0]), .count(count)
    );

    assign rsp.f0 = out_status;
    assign rsp.f1 = out_count;
endmodule

[rtl/core/dst_datapath.sv]
// Datapath of the search tree engine: node memories, free stack, walk pointers.
// Depends on dst_pkg; driven by dst_ctrl commands.
module dst_datapath #(
    parameter int POOL_SIZE = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dst_pkg::dst_cmd_t                 cmd,
    output dst_pkg::dst_stat_t                stat,
    input  logic [KEY_WIDTH-1:0]              in_key,
    output logic [$clog2(POOL_SIZE+1)-1:0]    count
);
    import dst_pkg::*;

    localparam int IW = $clog2(POOL_SIZE);
    localparam int LW = $clog2(POOL_SIZE + 1);
    localparam int DW = $clog2(KEY_WIDTH + 1);
    localparam int KW = $clog2(KEY_WIDTH);
    localparam logic [LW-1:0] NIL = LW'(POOL_SIZE);

    // Node memories and free stack.
    logic [KEY_WIDTH-1:0] key_mem   [POOL_SIZE];
    logic [LW-1:0]        left_mem  [POOL_SIZE];
    logic [LW-1:0]        right_mem [POOL_SIZE];
    logic [IW-1:0]        free_mem  [POOL_SIZE];

    logic [KEY_WIDTH-1:0] key_reg;
    logic [LW-1:0]        cur_reg, par_reg, leaf_reg, lpar_reg;
    logic                 side_reg, lside_reg;
    logic [DW-1:0]        depth_reg;
    logic [LW-1:0]        root_reg, top_reg, count_reg;
    logic [KEY_WIDTH-1:0] rd_key_reg;
    logic [LW-1:0]        rd_left_reg, rd_right_reg;
    logic [IW-1:0]        rd_free_reg;
    logic [LW-1:0]        sweep_reg;  // Fills the free stack and clears links after reset.
    logic                 key_bit;
    logic [LW-1:0]        rd_addr;

    assign count   = count_reg;
    assign key_bit = (depth_reg < DW'(KEY_WIDTH))
                   ? key_reg[KW'(KEY_WIDTH - 1 - int'(depth_reg))] : 1'b0;
    assign rd_addr = cmd.rd_leaf_key ? leaf_reg : cur_reg;

    assign stat.cur_nil    = (cur_reg == NIL);
    assign stat.key_hit    = (rd_key_reg == key_reg);
    assign stat.is_leaf    = (rd_left_reg == NIL) && (rd_right_reg == NIL);
    assign stat.pool_empty = (top_reg == '0);
    assign stat.filling    = (sweep_reg != NIL);

    // Registered memory reads.
    always_ff @(posedge clk)
    begin
        rd_key_reg   <= key_mem[rd_addr[IW-1:0]];
        rd_left_reg  <= left_mem[rd_addr[IW-1:0]];
        rd_right_reg <= right_mem[rd_addr[IW-1:0]];
        rd_free_reg  <= free_mem[IW'(top_reg - LW'(1))];
    end

    // Free stack write: initial fill sweep, then pushes of freed leaves.
    always_ff @(posedge clk)
    begin
        if (sweep_reg != NIL)
        begin
            free_mem[sweep_reg[IW-1:0]] <= IW'(NIL - LW'(1) - sweep_reg);
        end
        else if (cmd.do_remove)
        begin
            free_mem[top_reg[IW-1:0]] <= leaf_reg[IW-1:0];
        end
    end

    // Node memory writes. The fill pass clears every link, and only leaves are
    // ever freed, so a node taken from the free stack already has null links.
    always_ff @(posedge clk)
    begin
        if (sweep_reg != NIL)
        begin
            left_mem[sweep_reg[IW-1:0]]  <= NIL;
            right_mem[sweep_reg[IW-1:0]] <= NIL;
        end
        else if (cmd.do_insert)
        begin
            key_mem[rd_free_reg] <= key_reg;
            if (par_reg != NIL)
            begin
                if (side_reg)
                    right_mem[par_reg[IW-1:0]] <= LW'(rd_free_reg);
                else
                    left_mem[par_reg[IW-1:0]] <= LW'(rd_free_reg);
            end
        end
        else if (cmd.do_remove)
        begin
            if (leaf_reg != cur_reg)
                key_mem[cur_reg[IW-1:0]] <= rd_key_reg;
            if (lpar_reg != NIL)
            begin
                if (lside_reg)
                    right_mem[lpar_reg[IW-1:0]] <= NIL;
                else
                    left_mem[lpar_reg[IW-1:0]] <= NIL;
            end
        end
    end

    // Walk pointers and tree bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
            root_reg  <= NIL;
            top_reg   <= LW'(POOL_SIZE);
            count_reg <= '0;
            cur_reg   <= NIL;
            par_reg   <= NIL;
            leaf_reg  <= NIL;
            lpar_reg  <= NIL;
            side_reg  <= 1'b0;
            lside_reg <= 1'b0;
            depth_reg <= '0;
            key_reg   <= '0;
        end
        else
        begin
            if (sweep_reg != NIL)
                sweep_reg <= sweep_reg + LW'(1);
            if (cmd.load)
            begin
                key_reg   <= in_key;
                cur_reg   <= root_reg;
                par_reg   <= NIL;
                side_reg  <= 1'b0;
                depth_reg <= '0;
            end
            if (cmd.step_find)
            begin
                par_reg  <= cur_reg;
                side_reg <= key_bit;
                cur_reg  <= key_bit ? rd_right_reg : rd_left_reg;
                if (depth_reg < DW'(KEY_WIDTH))
                    depth_reg <= depth_reg + DW'(1);
            end
            if (cmd.rd_cur)
            begin
                leaf_reg  <= cur_reg;
                lpar_reg  <= par_reg;
                lside_reg <= side_reg;
            end
            if (cmd.step_leaf)
            begin
                lpar_reg <= leaf_reg;
                if (rd_left_reg != NIL)
                begin
                    lside_reg <= 1'b0;
                    leaf_reg  <= rd_left_reg;
                end
                else
                begin
                    lside_reg <= 1'b1;
                    leaf_reg  <= rd_right_reg;
                end
            end
            if (cmd.do_insert)
            begin
                top_reg   <= top_reg - LW'(1);
                count_reg <= count_reg + LW'(1);
                if (par_reg == NIL)
                    root_reg <= LW'(rd_free_reg);
            end
            if (cmd.do_remove)
            begin
                top_reg <= top_reg + LW'(1);
                if (count_reg != '0)
                    count_reg <= count_reg - LW'(1);
                if (lpar_reg == NIL)
                    root_reg <= NIL;
            end
        end
    end

    property p_count_bounded;
        @(posedge clk) disable iff (!rst_n) count_reg <= LW'(POOL_SIZE);
    endproperty
    a_count_bounded: assert property (p_count_bounded) else $error("count overflow");

    property p_stack_sum;
        @(posedge clk) disable iff (!rst_n)
            (sweep_reg == NIL) |-> (int'(top_reg) + int'(count_reg) == POOL_SIZE);
    endproperty
    a_stack_sum: assert property (p_stack_sum) else $error("free stack and count disagree");

    property p_insert_grows;
        @(posedge clk) disable iff (!rst_n)
            cmd.do_insert |=> (count_reg == $past(count_reg) + LW'(1));
    endproperty
    a_insert_grows: assert property (p_insert_grows) else $error("insert lost count");
endmodule

[rtl/core/dst_ctrl.sv]
// Controller of the search tree engine: sequences walks and the result register.
// Depends on dst_pkg; drives dst_datapath.
module dst_ctrl #(
    parameter int POOL_SIZE = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [dst_pkg::MODE_W-1:0]       in_mode,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [dst_pkg::STATUS_W-1:0]     out_status,
    output logic [$clog2(POOL_SIZE+1)-1:0]   out_count,
    input  logic [$clog2(POOL_SIZE+1)-1:0]   count,
    input  dst_pkg::dst_stat_t               stat,
    output dst_pkg::dst_cmd_t                cmd
);
    import dst_pkg::*;

    localparam int LW = $clog2(POOL_SIZE + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_READ, S_CMP, S_POP, S_INS,
        S_LREAD, S_LCHK, S_LKEY, S_REM, S_DONE
    } state_t;

    state_t               state_reg, state_next;
    mode_t                mode_reg;
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 finish;

    assign in_ready   = (state_reg == S_IDLE) && !stat.filling
                      && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        finish      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.cur_nil)
                begin
                    if (mode_reg == MODE_INSERT)
                        state_next = stat.pool_empty ? S_DONE : S_POP;
                    else
                        state_next = S_DONE;
                    status_next = (mode_reg == MODE_INSERT)
                                ? (stat.pool_empty ? ST_FULL : ST_INSERTED) : ST_ABSENT;
                end
                else
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_CMP;
            S_CMP:
            begin
                if (stat.key_hit)
                begin
                    unique case (mode_reg)
                        MODE_INSERT: begin status_next = ST_PRESENT; state_next = S_DONE; end
                        MODE_REMOVE: begin status_next = ST_REMOVED; state_next = S_LCHK; end
                        default:     begin status_next = ST_FOUND;   state_next = S_DONE; end
                    endcase
                end
                else
                begin
                    cmd.step_find = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_POP: state_next = S_INS;
            S_INS:
            begin
                cmd.do_insert = 1'b1;
                state_next    = S_DONE;
            end
            S_LCHK:
            begin
                if (stat.is_leaf)
                begin
                    cmd.rd_leaf_key = 1'b1;
                    state_next      = S_LKEY;
                end
                else
                begin
                    cmd.step_leaf = 1'b1;
                    state_next    = S_LREAD;
                end
            end
            S_LREAD:
            begin
                cmd.rd_leaf_key = 1'b1;
                state_next      = S_LCHK;
            end
            // Keep the read on the leaf so its key is still held for the move.
            S_LKEY:
            begin
                cmd.rd_leaf_key = 1'b1;
                state_next      = S_REM;
            end
            S_REM:
            begin
                cmd.do_remove = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                finish     = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_INSERT;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_INSERTED;
            out_count     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            if (cmd.load)
                mode_reg <= mode_t'(in_mode);
            if (finish)
            begin
                out_valid_reg <= 1'b1;
                out_count     <= LW'(count);
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    property p_accept_idle;
        @(posedge clk) disable iff (!rst_n)
            (in_valid && in_ready) |=> (state_reg == S_CHECK);
    endproperty
    a_accept_idle: assert property (p_accept_idle) else $error("accept outside idle");

    property p_done_valid;
        @(posedge clk) disable iff (!rst_n) (state_reg == S_DONE) |=> out_valid_reg;
    endproperty
    a_done_valid: assert property (p_done_valid) else $error("result lost");

    property p_one_op;
        @(posedge clk) disable iff (!rst_n) $onehot0({cmd.do_insert, cmd.do_remove, cmd.load});
    endproperty
    a_one_op: assert property (p_one_op) else $error("overlapping commands");
endmodule
